@@ src/kch_pkg.sv @@
// Shared types, constants and helper functions for the k-mer canonical hasher.
package kch_pkg;

    localparam int K_MAX      = 32;
    localparam int IDX_W      = $clog2(K_MAX);
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DROP_AMB    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_UPPER = 2'd2;

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = 6'd16;

    // MurmurHash3 x64_128 constants
    localparam logic [63:0] HASH_SEED = 64'd42;
    localparam logic [63:0] MM_C1     = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2     = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_M1   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_M2   = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] MM_ADD1   = 64'h0000000052dce729;
    localparam logic [63:0] MM_ADD2   = 64'h0000000038495ab5;

    typedef struct packed {
        logic [7:0] base_char;
        logic       seq_end;
    } in_t;

    typedef struct packed {
        logic [63:0] kmer_hash;
        logic        ambiguous;
        logic        seq_last;
    } out_t;

    // one hashing job handed from the front to the back
    typedef struct packed {
        logic [K_MAX-1:0][7:0] chars;     // newest character at the top index
        logic [LEN_W-1:0]      len;       // clamped window length
        logic                  drop;      // ambiguous window with dropping on
        logic                  seq_last;
    } job_t;

    function automatic logic [LEN_W-1:0] clamp_k(input logic [LEN_W-1:0] k);
        logic [LEN_W-1:0] r;
        r = k;
        if (k == '0)
            r = LEN_W'(1);
        else if (k > LEN_W'(K_MAX))
            r = LEN_W'(K_MAX);
        return r;
    endfunction

    function automatic logic is_acgt(input logic [7:0] c);
        return (c == 8'h41) || (c == 8'h43) || (c == 8'h47) || (c == 8'h54);
    endfunction

endpackage

@@ src/kch_front.sv @@
// Front end: configuration, case folding, sliding window and job issue.
module kch_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  kch_pkg::in_t       in_data,
    input  logic               cfg_we,
    input  logic [kch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kch_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic               push,
    output kch_pkg::job_t      push_job,
    input  logic               q_full
);
    import kch_pkg::*;

    logic [LEN_W-1:0]      kmer_len_reg;
    logic                  drop_reg;
    logic                  upper_reg;
    logic [K_MAX-1:0][7:0] win_reg, win_next;
    logic [K_MAX-1:0]      bad_reg, bad_next;
    logic [LEN_W-1:0]      fill_reg, fill_next;

    logic             accept;
    logic [7:0]       c;
    logic [LEN_W-1:0] k;
    logic [K_MAX-1:0] mask;
    logic             amb;
    logic             emit;

    // fold case and shift the new character in
    always_comb
    begin
        accept = in_valid && !q_full;
        in_stall = q_full;
        c = in_data.base_char;
        if (upper_reg && c >= 8'h61 && c <= 8'h7a)
            c = c - 8'd32;
        k = clamp_k(kmer_len_reg);
        win_next = {c, win_reg[K_MAX-1:1]};
        bad_next = {!is_acgt(c), bad_reg[K_MAX-1:1]};
        fill_next = (fill_reg == LEN_W'(K_MAX)) ? fill_reg : fill_reg + LEN_W'(1);
        emit = fill_next >= k;
        mask = ~({K_MAX{1'b1}} >> k);
        amb = |(bad_next & mask);
        push = accept && emit;
        push_job.chars = win_next;
        push_job.len = k;
        push_job.drop = amb && drop_reg;
        push_job.seq_last = in_data.seq_end;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_len_reg <= KMER_LEN_RESET;
            drop_reg <= 1'b1;
            upper_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KMER_LEN:    kmer_len_reg <= cfg_data;
                REG_DROP_AMB:    drop_reg <= cfg_data[0];
                REG_FORCE_UPPER: upper_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // window and fill; clear at end of sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            bad_reg <= '1;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            if (in_data.seq_end)
            begin
                win_reg <= '0;
                bad_reg <= '1;
                fill_reg <= '0;
            end
            else
            begin
                win_reg <= win_next;
                bad_reg <= bad_next;
                fill_reg <= fill_next;
            end
        end
    end

endmodule

@@ src/kch_queue.sv @@
// Two-entry job queue between the front end and the hash engine.
module kch_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  kch_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output kch_pkg::job_t head
);
    import kch_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ src/kch_back.sv @@
// Hash engine: sequenced MurmurHash3 over both window orientations, output register.
module kch_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  kch_pkg::job_t job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output kch_pkg::out_t out_data
);
    import kch_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NEXT = 4'd1;
    localparam logic [3:0] ST_LOAD = 4'd2;
    localparam logic [3:0] ST_MUL  = 4'd3;
    localparam logic [3:0] ST_ROTK = 4'd4;
    localparam logic [3:0] ST_XORH = 4'd5;
    localparam logic [3:0] ST_ROTH = 4'd6;
    localparam logic [3:0] ST_ADDC = 4'd7;
    localparam logic [3:0] ST_FIN1 = 4'd8;
    localparam logic [3:0] ST_FIN2 = 4'd9;
    localparam logic [3:0] ST_FMX0 = 4'd10;
    localparam logic [3:0] ST_FMX1 = 4'd11;
    localparam logic [3:0] ST_FMX2 = 4'd12;
    localparam logic [3:0] ST_FIN3 = 4'd13;
    localparam logic [3:0] ST_OUT  = 4'd14;

    // control
    logic [3:0] state_reg, state_next;
    logic [3:0] mret_reg, mret_next;
    logic [1:0] mph_reg, mph_next;
    logic       dir_reg, dir_next;
    logic [1:0] blk_reg, blk_next;
    logic       lane_reg, lane_next;
    logic       fsel_reg, fsel_next;
    logic       out_valid_reg, out_valid_next;

    // payload
    logic [K_MAX-1:0][7:0] win_reg, win_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  last_reg, last_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    logic [63:0] k_reg, k_next;
    logic [63:0] mc_reg, mc_next;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next;
    logic [31:0] p2_reg, p2_next;
    logic [63:0] fwd_reg, fwd_next;
    logic [63:0] res_reg, res_next;
    logic        amb_reg, amb_next;
    out_t        out_data_reg, out_data_next;

    logic [1:0]       nb;
    logic [3:0]       tail;
    logic [LEN_W-1:0] off;
    logic [63:0]      load_val;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      prod;
    logic [63:0]      kx, sum, word;

    assign nb = len_reg[5:4];
    assign tail = len_reg[3:0];
    assign off = {blk_reg, lane_reg, 3'b000};
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    // gather up to eight window bytes for the current lane
    always_comb
    begin
        logic [LEN_W-1:0] j;
        logic [IDX_W-1:0] idx;
        load_val = '0;
        for (int i = 0; i < 8; i++)
        begin
            j = off + LEN_W'(i);
            idx = dir_reg ? ~j[IDX_W-1:0] : (j[IDX_W-1:0] - len_reg[IDX_W-1:0]);
            load_val[8*i +: 8] = (j < len_reg) ? win_reg[idx] : 8'd0;
        end
    end

    // shared 32x32 multiplier
    always_comb
    begin
        mul_a = (mph_reg == 2'd2) ? k_reg[63:32] : k_reg[31:0];
        mul_b = (mph_reg == 2'd1) ? mc_reg[63:32] : mc_reg[31:0];
        prod = mul_a * mul_b;
    end

    assign kx = k_reg ^ (k_reg >> 33);
    assign sum = h1_reg + h2_reg;
    assign word = {sum[31:0], sum[63:32]};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mret_next = mret_reg;
        mph_next = mph_reg;
        dir_next = dir_reg;
        blk_next = blk_reg;
        lane_next = lane_reg;
        fsel_next = fsel_reg;
        win_next = win_reg;
        len_next = len_reg;
        last_next = last_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        k_next = k_reg;
        mc_next = mc_reg;
        p0_next = p0_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        fwd_next = fwd_reg;
        res_next = res_reg;
        amb_next = amb_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        pop = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    pop = 1'b1;
                    win_next = job.chars;
                    len_next = job.len;
                    last_next = job.seq_last;
                    h1_next = HASH_SEED;
                    h2_next = HASH_SEED;
                    dir_next = 1'b0;
                    blk_next = 2'd0;
                    lane_next = (job.len[5:4] == 2'd0);
                    if (job.drop)
                    begin
                        res_next = '0;
                        amb_next = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        amb_next = 1'b0;
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_NEXT:
            begin
                if (blk_reg < nb)
                    state_next = ST_LOAD;
                else if (lane_reg)
                begin
                    if (tail > 4'd8)
                        state_next = ST_LOAD;
                    else
                        lane_next = 1'b0;
                end
                else if (tail != 4'd0)
                    state_next = ST_LOAD;
                else
                    state_next = ST_FIN1;
            end
            ST_LOAD:
            begin
                k_next = load_val;
                mc_next = lane_reg ? MM_C2 : MM_C1;
                mret_next = ST_ROTK;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                mph_next = mph_reg + 2'd1;
                case (mph_reg)
                    2'd0: p0_next = prod;
                    2'd1: p1_next = prod[31:0];
                    2'd2: p2_next = prod[31:0];
                    default:
                    begin
                        k_next = p0_reg + {p1_reg + p2_reg, 32'd0};
                        state_next = mret_reg;
                    end
                endcase
            end
            ST_ROTK:
            begin
                k_next = lane_reg ? {k_reg[30:0], k_reg[63:31]} : {k_reg[32:0], k_reg[63:33]};
                mc_next = lane_reg ? MM_C1 : MM_C2;
                mret_next = ST_XORH;
                state_next = ST_MUL;
            end
            ST_XORH:
            begin
                if (lane_reg)
                    h2_next = h2_reg ^ k_reg;
                else
                    h1_next = h1_reg ^ k_reg;
                if (blk_reg < nb)
                    state_next = ST_ROTH;
                else if (lane_reg)
                begin
                    lane_next = 1'b0;
                    state_next = ST_NEXT;
                end
                else
                    state_next = ST_FIN1;
            end
            ST_ROTH:
            begin
                if (lane_reg)
                    h2_next = {h2_reg[32:0], h2_reg[63:33]} + h1_reg;
                else
                    h1_next = {h1_reg[36:0], h1_reg[63:37]} + h2_reg;
                state_next = ST_ADDC;
            end
            ST_ADDC:
            begin
                if (lane_reg)
                begin
                    h2_next = (h2_reg << 2) + h2_reg + MM_ADD2;
                    blk_next = blk_reg + 2'd1;
                    lane_next = !((blk_reg + 2'd1) < nb);
                end
                else
                begin
                    h1_next = (h1_reg << 2) + h1_reg + MM_ADD1;
                    lane_next = 1'b1;
                end
                state_next = ST_NEXT;
            end
            ST_FIN1:
            begin
                h1_next = (h1_reg ^ 64'(len_reg)) + (h2_reg ^ 64'(len_reg));
                h2_next = h2_reg ^ 64'(len_reg);
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                h2_next = h2_reg + h1_reg;
                k_next = h1_reg;
                fsel_next = 1'b0;
                state_next = ST_FMX0;
            end
            ST_FMX0:
            begin
                k_next = kx;
                mc_next = FMIX_M1;
                mret_next = ST_FMX1;
                state_next = ST_MUL;
            end
            ST_FMX1:
            begin
                k_next = kx;
                mc_next = FMIX_M2;
                mret_next = ST_FMX2;
                state_next = ST_MUL;
            end
            ST_FMX2:
            begin
                if (!fsel_reg)
                begin
                    h1_next = kx;
                    k_next = h2_reg;
                    fsel_next = 1'b1;
                    state_next = ST_FMX0;
                end
                else
                begin
                    h2_next = kx;
                    state_next = ST_FIN3;
                end
            end
            ST_FIN3:
            begin
                if (!dir_reg)
                begin
                    fwd_next = word;
                    dir_next = 1'b1;
                    h1_next = HASH_SEED;
                    h2_next = HASH_SEED;
                    blk_next = 2'd0;
                    lane_next = (nb == 2'd0);
                    state_next = ST_NEXT;
                end
                else
                begin
                    res_next = (fwd_reg < word) ? fwd_reg : word;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.kmer_hash = res_reg;
                    out_data_next.ambiguous = amb_reg;
                    out_data_next.seq_last = last_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mret_reg <= ST_IDLE;
            mph_reg <= 2'd0;
            dir_reg <= 1'b0;
            blk_reg <= 2'd0;
            lane_reg <= 1'b0;
            fsel_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mret_reg <= mret_next;
            mph_reg <= mph_next;
            dir_reg <= dir_next;
            blk_reg <= blk_next;
            lane_reg <= lane_next;
            fsel_reg <= fsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        len_reg <= len_next;
        last_reg <= last_next;
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        k_reg <= k_next;
        mc_reg <= mc_next;
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        fwd_reg <= fwd_next;
        res_reg <= res_next;
        amb_reg <= amb_next;
        out_data_reg <= out_data_next;
    end

    // multiplier phase only runs inside a multiply
    a_mph_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (mph_reg == 2'd0))
        else $error("multiplier phase active outside multiply");

    // block index never passes the block count while hashing
    a_blk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_OUT) |-> (blk_reg <= nb))
        else $error("block index beyond block count");

    // second orientation finished goes straight to the output stage
    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN3 && dir_reg) |=> (state_reg == ST_OUT))
        else $error("final hash did not reach output stage");

endmodule

@@ src/kmer_canonical_hasher_top.sv @@
// The hash sequencer works on one job at a time and hashes both window orientations with its
// shared 32x32 multiplier, building each 64-bit multiply from partial products. While it is
// busy the front end keeps accepting characters and the queue holds up to two pending jobs;
// in_stall rises when the queue is full. Ambiguous windows with dropping on skip hashing, and
// characters that produce no job do not enter the queue.
// Reset (rst_n low, async) empties window, queue and output; config returns to k=16, 1, 1.
module kmer_canonical_hasher_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  kch_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output kch_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [kch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kch_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kch_pkg::*;

    logic push;
    job_t push_job;
    logic q_full;
    logic q_empty;
    logic pop;
    job_t head;

    // accept characters and build jobs
    kch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_job  (push_job),
        .q_full    (q_full)
    );

    // hold pending jobs
    kch_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    // hash and deliver
    kch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_empty),
        .job       (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
